@@ hdl/rapv_pkg.sv @@
// shared constants and arithmetic helpers for the rotate and plot vertex core
`timescale 1ns / 1ps

package rapv_pkg;

  localparam int VERTEX_COUNT_DEF = 512;

  // field widths
  localparam int IDX_W    = 9;
  localparam int COORD_W  = 16;
  localparam int ANGLE_W  = 9;
  localparam int TRIG_W   = 14;
  localparam int PROD_W   = COORD_W + TRIG_W;
  localparam int OFFS_W   = 13;
  localparam int SLOT_W   = 3;
  localparam int COLOR_W  = 4;
  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 24;
  localparam int APB_A_W  = 3;
  localparam int APB_D_W  = 32;

  // reciprocal shift for the vertex index reduction
  localparam int RECIP_S = 22;

  // register indexes
  localparam logic REG_SHIFT_X = 1'b0;
  localparam logic REG_SHIFT_Y = 1'b1;

  // screen constants
  localparam logic [7:0] CENTER_X  = 8'd120;
  localparam logic [7:0] CENTER_Y  = 8'd80;
  localparam logic [7:0] ROW_WORDS = 8'd240;
  localparam logic [7:0] SHIFT_X_RST = 8'd0;
  localparam logic [7:0] SHIFT_Y_RST = 8'd30;

  // write sequence
  localparam logic [3:0] DRAW_START = 4'd5;
  localparam logic [3:0] LAST_WRITE = 4'd9;

  // mark arms
  localparam logic [2:0] ARM_RIGHT  = 3'd0;
  localparam logic [2:0] ARM_LEFT   = 3'd1;
  localparam logic [2:0] ARM_CENTER = 3'd2;
  localparam logic [2:0] ARM_DOWN   = 3'd3;
  localparam logic [2:0] ARM_UP     = 3'd4;

  // quarter wave sine, q12
  function automatic logic [12:0] sine_quarter(input logic [6:0] d);
    logic [12:0] v;
    case (d)
      7'd0: v = 13'd0;       7'd1: v = 13'd71;      7'd2: v = 13'd142;
      7'd3: v = 13'd214;     7'd4: v = 13'd285;     7'd5: v = 13'd356;
      7'd6: v = 13'd428;     7'd7: v = 13'd499;     7'd8: v = 13'd570;
      7'd9: v = 13'd640;     7'd10: v = 13'd711;    7'd11: v = 13'd781;
      7'd12: v = 13'd851;    7'd13: v = 13'd921;    7'd14: v = 13'd990;
      7'd15: v = 13'd1060;   7'd16: v = 13'd1129;   7'd17: v = 13'd1197;
      7'd18: v = 13'd1265;   7'd19: v = 13'd1333;   7'd20: v = 13'd1400;
      7'd21: v = 13'd1467;   7'd22: v = 13'd1534;   7'd23: v = 13'd1600;
      7'd24: v = 13'd1665;   7'd25: v = 13'd1731;   7'd26: v = 13'd1795;
      7'd27: v = 13'd1859;   7'd28: v = 13'd1922;   7'd29: v = 13'd1985;
      7'd30: v = 13'd2048;   7'd31: v = 13'd2109;   7'd32: v = 13'd2170;
      7'd33: v = 13'd2230;   7'd34: v = 13'd2290;   7'd35: v = 13'd2349;
      7'd36: v = 13'd2407;   7'd37: v = 13'd2465;   7'd38: v = 13'd2521;
      7'd39: v = 13'd2577;   7'd40: v = 13'd2632;   7'd41: v = 13'd2687;
      7'd42: v = 13'd2740;   7'd43: v = 13'd2793;   7'd44: v = 13'd2845;
      7'd45: v = 13'd2896;   7'd46: v = 13'd2946;   7'd47: v = 13'd2995;
      7'd48: v = 13'd3043;   7'd49: v = 13'd3091;   7'd50: v = 13'd3137;
      7'd51: v = 13'd3183;   7'd52: v = 13'd3227;   7'd53: v = 13'd3271;
      7'd54: v = 13'd3313;   7'd55: v = 13'd3355;   7'd56: v = 13'd3395;
      7'd57: v = 13'd3435;   7'd58: v = 13'd3473;   7'd59: v = 13'd3510;
      7'd60: v = 13'd3547;   7'd61: v = 13'd3582;   7'd62: v = 13'd3616;
      7'd63: v = 13'd3649;   7'd64: v = 13'd3681;   7'd65: v = 13'd3712;
      7'd66: v = 13'd3741;   7'd67: v = 13'd3770;   7'd68: v = 13'd3797;
      7'd69: v = 13'd3823;   7'd70: v = 13'd3848;   7'd71: v = 13'd3872;
      7'd72: v = 13'd3895;   7'd73: v = 13'd3917;   7'd74: v = 13'd3937;
      7'd75: v = 13'd3956;   7'd76: v = 13'd3974;   7'd77: v = 13'd3991;
      7'd78: v = 13'd4006;   7'd79: v = 13'd4020;   7'd80: v = 13'd4033;
      7'd81: v = 13'd4045;   7'd82: v = 13'd4056;   7'd83: v = 13'd4065;
      7'd84: v = 13'd4073;   7'd85: v = 13'd4080;   7'd86: v = 13'd4086;
      7'd87: v = 13'd4090;   7'd88: v = 13'd4093;   7'd89: v = 13'd4095;
      default: v = 13'd4096;
    endcase
    return v;
  endfunction

  // signed q12 sine of an angle below 720 degrees
  function automatic logic signed [TRIG_W-1:0] sine_q12(input logic [9:0] a);
    logic [1:0]  half;
    logic [9:0]  base;
    logic [9:0]  m;
    logic [6:0]  d;
    logic [12:0] mag;
    half = (a >= 10'd540) ? 2'd3 : (a >= 10'd360) ? 2'd2 : (a >= 10'd180) ? 2'd1 : 2'd0;
    case (half)
      2'd0: base = 10'd0;
      2'd1: base = 10'd180;
      2'd2: base = 10'd360;
      default: base = 10'd540;
    endcase
    m   = a - base;
    d   = (m < 10'd91) ? m[6:0] : 7'(10'd180 - m);
    mag = sine_quarter(d);
    return half[0] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  // product divided by 4096 toward zero, wrapped to 16 bits
  function automatic logic [COORD_W-1:0] q12_trunc(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p[PROD_W-1] ? p + PROD_W'(4095) : p;
    return t[COORD_W+11:12];
  endfunction

endpackage

@@ hdl/rotate_and_plot_vertex_core.sv @@
// y axis vertex rotation and plus mark plotter for a 4bpp tiled canvas
`timescale 1ns / 1ps
// the first write word reaches the output register through the stage 0 to 3 registers
// throughput: ten write words per vertex, one per cycle while m_tready is high,
//   bounded by the single output channel; a new vertex may enter while one drains
// reset: shift_x = 0, shift_y = 30, pipeline emptied, then a clearing pass over all
//   VERTEX_COUNT entries zeroes the position memory while s_tready stays low

module rotate_and_plot_vertex_core #(
  parameter int VERTEX_COUNT = rapv_pkg::VERTEX_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // vertex_index, pos_x, pos_y, pos_z, angle_deg
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [rapv_pkg::S_DATA_W-1:0]  s_tdata,
  // word_offset, nibble_slot, pixel_color
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [rapv_pkg::M_DATA_W-1:0]  m_tdata,
  output logic                           m_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rapv_pkg::APB_A_W-1:0]   paddr,
  input  logic [rapv_pkg::APB_D_W-1:0]   pwdata,
  output logic [rapv_pkg::APB_D_W-1:0]   prdata,
  output logic                           pready
);

  localparam int ADDR_W = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int REM_W  = rapv_pkg::RECIP_S;
  localparam logic [31:0] RECIP_M =
    32'((64'(1) << rapv_pkg::RECIP_S) + 64'(VERTEX_COUNT) - 64'(1)) / 32'(VERTEX_COUNT);
  localparam int CW = rapv_pkg::COORD_W;
  localparam int TW = rapv_pkg::TRIG_W;
  localparam int PW = rapv_pkg::PROD_W;
  localparam int IW = rapv_pkg::IDX_W;

  // configuration
  logic signed [7:0] shift_x;
  logic signed [7:0] shift_y;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = paddr[2] ? {{24{shift_y[7]}}, shift_y} : {{24{shift_x[7]}}, shift_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_x <= rapv_pkg::SHIFT_X_RST;
      shift_y <= rapv_pkg::SHIFT_Y_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        rapv_pkg::REG_SHIFT_X: shift_x <= pwdata[7:0];
        rapv_pkg::REG_SHIFT_Y: shift_y <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // clearing pass
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(VERTEX_COUNT - 1)) clearing <= 1'b0;
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // pipeline control
  logic       v0, v1, v2, v3;
  logic [3:0] cnt;
  logic       out_ld, emit, s3_done, s3_free, s2_free, s1_free, s0_free;
  logic       adv0, adv1, adv2, s_acc;

  assign out_ld  = !m_tvalid || m_tready;
  assign emit    = v3 && out_ld;
  assign s3_done = emit && (cnt == rapv_pkg::LAST_WRITE);
  assign s3_free = !v3 || s3_done;
  assign adv2    = v2 && s3_free;
  assign s2_free = !v2 || s3_free;
  assign adv1    = v1 && s2_free;
  assign s1_free = !v1 || s2_free;
  assign adv0    = v0 && s1_free;
  assign s0_free = !v0 || s1_free;
  assign s_tready = s0_free && !clearing;
  assign s_acc   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      cnt <= '0;
    end else begin
      if (s_acc) v0 <= 1'b1;
      else if (adv0) v0 <= 1'b0;
      if (adv0) v1 <= 1'b1;
      else if (adv1) v1 <= 1'b0;
      if (adv1) v2 <= 1'b1;
      else if (adv2) v2 <= 1'b0;
      if (adv2) v3 <= 1'b1;
      else if (s3_done) v3 <= 1'b0;
      if (emit) cnt <= s3_done ? 4'd0 : cnt + 4'd1;
    end
  end

  // stage 0: input word, trig lookup, index quotient
  logic [IW-1:0]               in_idx;
  logic signed [CW-1:0]        in_x, in_y, in_z;
  logic [rapv_pkg::ANGLE_W-1:0] in_ang;
  logic signed [TW-1:0]        sin_v, cos_v;
  logic [31:0]                 rq_prod;

  always_ff @(posedge clk) begin
    if (s_acc) begin
      in_idx <= s_tdata[8:0];
      in_x   <= s_tdata[24:9];
      in_y   <= s_tdata[40:25];
      in_z   <= s_tdata[56:41];
      in_ang <= s_tdata[65:57];
    end
  end

  assign sin_v   = rapv_pkg::sine_q12({1'b0, in_ang});
  assign cos_v   = rapv_pkg::sine_q12({1'b0, in_ang} + 10'd90);
  assign rq_prod = 32'(in_idx) * RECIP_M;

  // stage 1: products, index remainder
  logic [IW-1:0]        s1_idx, s1_q;
  logic signed [CW-1:0] s1_x, s1_z;
  logic [7:0]           s1_y8;
  logic signed [TW-1:0] s1_sin, s1_cos, s1_nsin;
  logic [REM_W-1:0]     rem;

  always_ff @(posedge clk) begin
    if (adv0) begin
      s1_idx <= in_idx;
      s1_q   <= rq_prod[IW+rapv_pkg::RECIP_S-1:rapv_pkg::RECIP_S];
      s1_x   <= in_x;
      s1_z   <= in_z;
      s1_y8  <= in_y[7:0];
      s1_sin <= sin_v;
      s1_cos <= cos_v;
    end
  end

  assign s1_nsin = -s1_sin;
  assign rem     = REM_W'(s1_idx) - REM_W'(s1_q) * REM_W'(VERTEX_COUNT);

  // stage 2: rotated coordinates, shade, position memory access
  logic [ADDR_W-1:0]    s2_addr;
  logic [7:0]           s2_y8;
  logic signed [PW-1:0] p_xc, p_zs, p_xs, p_zc;
  logic [CW-1:0]        rx;
  logic signed [CW-1:0] rz;
  logic signed [17:0]   shade_v, shade_t;
  logic [3:0]           shade;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_addr <= rem[ADDR_W-1:0];
      s2_y8   <= s1_y8;
      p_xc    <= s1_x * s1_cos;
      p_zs    <= s1_z * s1_nsin;
      p_xs    <= s1_x * s1_sin;
      p_zc    <= s1_z * s1_cos;
    end
  end

  assign rx      = rapv_pkg::q12_trunc(p_xc) + rapv_pkg::q12_trunc(p_zs);
  assign rz      = rapv_pkg::q12_trunc(p_xs) + rapv_pkg::q12_trunc(p_zc);
  assign shade_v = 18'sd120 - 18'(rz);
  assign shade_t = 18'sd21 - (shade_v >>> 4);
  assign shade   = shade_t[4:1] + 4'd2;

  // position memory: rotated x low byte, input y low byte
  logic [15:0]       prev_xy [VERTEX_COUNT];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic [15:0]       old_xy;

  assign mem_we    = clearing || adv2;
  assign mem_waddr = clearing ? clr_addr : s2_addr;
  assign mem_wdata = clearing ? 16'd0 : {s2_y8, rx[7:0]};

  always_ff @(posedge clk) begin
    if (mem_we) prev_xy[mem_waddr] <= mem_wdata;
    if (adv2) old_xy <= prev_xy[s2_addr];
  end

  // stage 3: write sequencer
  logic [7:0] s3_nx, s3_ny;
  logic [3:0] s3_color;
  logic       erase;
  logic [7:0] bx, by, cx, cy, px, py;
  logic [2:0] arm;
  logic [rapv_pkg::OFFS_W-1:0] offs;

  always_ff @(posedge clk) begin
    if (adv2) begin
      s3_nx    <= rx[7:0];
      s3_ny    <= s2_y8;
      s3_color <= shade;
    end
  end

  assign erase = cnt < rapv_pkg::DRAW_START;
  assign bx    = erase ? old_xy[7:0] : s3_nx;
  assign by    = erase ? old_xy[15:8] : s3_ny;
  assign cx    = rapv_pkg::CENTER_X + bx + shift_x;
  assign cy    = rapv_pkg::CENTER_Y - by + shift_y;
  assign arm   = erase ? cnt[2:0] : 3'(cnt - rapv_pkg::DRAW_START);

  always_comb begin
    px = cx;
    py = cy;
    case (arm)
      rapv_pkg::ARM_RIGHT:  px = cx + 8'd1;
      rapv_pkg::ARM_LEFT:   px = cx - 8'd1;
      rapv_pkg::ARM_CENTER: ;
      rapv_pkg::ARM_DOWN:   py = cy + 8'd1;
      rapv_pkg::ARM_UP:     py = cy - 8'd1;
      default: ;
    endcase
  end

  assign offs = rapv_pkg::OFFS_W'({px[7:3], 3'b000})
              + rapv_pkg::OFFS_W'(py[7:3]) * rapv_pkg::OFFS_W'(rapv_pkg::ROW_WORDS)
              + rapv_pkg::OFFS_W'(py[2:0]);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ld) begin
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {4'b0000, (erase ? 4'd0 : s3_color), px[2:0], offs};
      m_tlast <= (cnt == rapv_pkg::LAST_WRITE);
    end
  end

endmodule
